### rtl/rdq_pkg.sv
// shared types, constants and codes of the dma double-buffer receive queue
package rdq_pkg;

    localparam int HALF_SIZE = 64;
    localparam int MAX_READ  = 32;
    localparam int RING_SIZE = 2 * HALF_SIZE;
    localparam int RING_W    = $clog2(RING_SIZE);
    // index arithmetic width, one bit above the ring index
    localparam int AW        = RING_W + 1;
    // width of a byte count within one read
    localparam int N_W       = $clog2(MAX_READ + 1);
    // command queue depth between front and back
    localparam int CQ_DEPTH  = 4;
    localparam int CQ_W      = $clog2(CQ_DEPTH);

    typedef enum logic [1:0] {
        OP_DEPOSIT = 2'd0,
        OP_PUBLISH = 2'd1,
        OP_READ    = 2'd2,
        OP_FLUSH   = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_INCONS = 2'd2;

    typedef enum logic [1:0] {
        CMD_SINGLE  = 2'd0,
        CMD_DEPOSIT = 2'd1,
        CMD_READ    = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] store_index;
        logic [7:0] store_byte;
        logic [6:0] new_write_index;
        logic [5:0] read_count;
    } in_word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] status;
        logic [7:0] published_count;
        logic       last;
    } out_word_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [RING_W-1:0] addr;
        logic [7:0]        wbyte;
        logic [N_W-1:0]    n;
        logic [1:0]        status;
        logic [7:0]        count;
    } cmd_t;

    // command queue status toward its neighbors
    typedef struct packed {
        logic full;
        logic valid;
    } cq_stat_t;

endpackage

### rtl/dma_double_buffer_rx_queue_top.sv
// top level of the dma double-buffer receive queue
// path: command queue, issue stage with the ring read, output register
// throughput: one input word per cycle while the command queue has room; one
//   result word per cycle unless rsp_stall; a read of n bytes yields n words
// the single read port of the ring memory sets the one-byte-per-cycle rate
// reset: indices and ready flag cleared at once, ring contents undefined
module dma_double_buffer_rx_queue_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  rdq_pkg::in_word_t  req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rdq_pkg::out_word_t rsp_word
);
    import rdq_pkg::*;

    logic     push, pop;
    cmd_t     push_cmd, head;
    cq_stat_t cq_stat;

    assign req_stall = cq_stat.full;

    // index keeping and classification
    rdq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_word  (req_word),
        .cq_full   (cq_stat.full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // command queue
    rdq_cmd_fifo u_cq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (cq_stat)
    );

    // ring access and result words
    rdq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cq_valid  (cq_stat.valid),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

### rtl/rdq_ram.sv
// generic single-write, single-read ram with registered read
module rdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/rdq_cmd_fifo.sv
// short command queue between front and back, head visible without a pop
module rdq_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rdq_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output rdq_pkg::cmd_t   head,
    output rdq_pkg::cq_stat_t stat
);
    import rdq_pkg::*;

    cmd_t          slot_reg [CQ_DEPTH];
    logic [CQ_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_W:0]   fill_reg, fill_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == CQ_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == CQ_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (int'(fill_reg) == CQ_DEPTH);
    assign stat.valid = (fill_reg != '0);

endmodule

### rtl/rdq_front.sv
// front end: accepts words, keeps the ring indices and classifies each operation
module rdq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  rdq_pkg::in_word_t req_word,
    input  logic              cq_full,
    output logic              push,
    output rdq_pkg::cmd_t     push_cmd
);
    import rdq_pkg::*;

    localparam logic [RING_W-1:0] HALF_IDX = RING_W'(HALF_SIZE);
    localparam logic [AW-1:0]     RING_A   = AW'(RING_SIZE);
    localparam logic [AW-1:0]     HALF_A   = AW'(HALF_SIZE);

    logic [RING_W-1:0] read_index_reg, read_index_next;
    logic [RING_W-1:0] write_index_reg, write_index_next;
    logic              data_ready_reg, data_ready_next;

    // publish evaluation
    logic [RING_W-1:0] t, ot, p;
    logic [AW-1:0]     pub_n;
    logic [1:0]        pub_st;
    logic [RING_W-1:0] pub_w, pub_r;
    logic [7:0]        pub_cnt;

    // read evaluation
    logic [N_W-1:0]    req;
    logic [AW-1:0]     avail;
    logic [N_W-1:0]    rd_n;
    logic [AW-1:0]     rd_end;

    assign push = req_valid && !cq_full;

    assign t  = RING_W'(req_word.new_write_index);
    assign ot = write_index_reg;
    assign p  = read_index_reg;

    // region rules of a publish, by old write index
    always_comb
    begin
        pub_st = ST_OK;
        pub_n  = '0;
        pub_w  = ot;
        pub_r  = p;
        if (int'(req_word.new_write_index) >= RING_SIZE)
        begin
            pub_st = ST_INCONS;
        end
        else if (t == ot)
        begin
            pub_n = '0;
        end
        else if (ot == '0)
        begin
            if (t > HALF_IDX)
            begin
                pub_n = AW'(t) - HALF_A;
                pub_w = t;
                pub_r = HALF_IDX;
            end
            else if (p == '0)
            begin
                pub_n = AW'(t);
                pub_w = t;
            end
            else if (p < HALF_IDX)
            begin
                pub_st = ST_INCONS;
            end
            else if (t == HALF_IDX)
            begin
                pub_n = AW'(p) - HALF_A;
                pub_w = HALF_IDX;
                pub_r = '0;
            end
        end
        else if (ot < HALF_IDX)
        begin
            if (p > ot)
            begin
                pub_st = ST_INCONS;
            end
            else if (t > HALF_IDX)
            begin
                pub_n = AW'(t) - HALF_A;
                pub_w = t;
                pub_r = HALF_IDX;
            end
            else if (t < ot)
            begin
                pub_st = ST_INCONS;
            end
            else
            begin
                pub_n = AW'(t) - AW'(ot);
                pub_w = t;
            end
        end
        else if (ot == HALF_IDX)
        begin
            if (t < HALF_IDX && t != '0)
            begin
                pub_n = AW'(t);
                pub_w = t;
                pub_r = '0;
            end
            else if (p == HALF_IDX)
            begin
                pub_n = (t == '0) ? HALF_A : AW'(t) - HALF_A;
                pub_w = t;
            end
            else if (p > HALF_IDX)
            begin
                pub_st = ST_INCONS;
            end
            else if (t == '0)
            begin
                pub_n = AW'(p);
                pub_w = '0;
                pub_r = HALF_IDX;
            end
        end
        else
        begin
            if (p < HALF_IDX || p > ot)
            begin
                pub_st = ST_INCONS;
            end
            else if (t < ot && t != '0)
            begin
                if (t > HALF_IDX)
                begin
                    pub_st = ST_INCONS;
                end
                else
                begin
                    pub_n = AW'(t);
                    pub_w = t;
                    pub_r = '0;
                end
            end
            else
            begin
                pub_n = (t == '0) ? RING_A - AW'(ot) : AW'(t) - AW'(ot);
                pub_w = t;
            end
        end
        if (pub_st != ST_OK)
        begin
            pub_n = '0;
            pub_w = ot;
            pub_r = p;
        end
    end

    // published count saturates at the field limit
    assign pub_cnt = (int'(pub_n) > 255) ? 8'hFF : 8'(pub_n);

    // read sizing: clamp the request, count the readable bytes
    always_comb
    begin
        if (int'(req_word.read_count) > MAX_READ)
        begin
            req = N_W'(MAX_READ);
        end
        else
        begin
            req = N_W'(req_word.read_count);
        end
        avail = AW'(write_index_reg) - AW'(read_index_reg)
              + ((write_index_reg < read_index_reg) ? RING_A : '0);
        rd_n  = (int'(avail) > int'(req)) ? req : N_W'(avail);
        rd_end = AW'(read_index_reg) + AW'(rd_n);
        if (rd_end >= RING_A)
        begin
            rd_end = rd_end - RING_A;
        end
    end

    // operation decode: next index state and the queued command
    always_comb
    begin
        read_index_next  = read_index_reg;
        write_index_next = write_index_reg;
        data_ready_next  = data_ready_reg;
        push_cmd.kind    = CMD_SINGLE;
        push_cmd.addr    = RING_W'(req_word.store_index);
        push_cmd.wbyte   = req_word.store_byte;
        push_cmd.n       = '0;
        push_cmd.status  = ST_OK;
        push_cmd.count   = '0;
        unique case (req_word.op)
            OP_DEPOSIT:
            begin
                if (int'(req_word.store_index) < RING_SIZE)
                begin
                    push_cmd.kind = CMD_DEPOSIT;
                end
            end
            OP_PUBLISH:
            begin
                push_cmd.status  = pub_st;
                push_cmd.count   = pub_cnt;
                write_index_next = pub_w;
                read_index_next  = pub_r;
                if (pub_n != '0)
                begin
                    data_ready_next = 1'b1;
                end
            end
            OP_READ:
            begin
                if (!data_ready_reg || req == '0)
                begin
                    push_cmd.status = ST_EMPTY;
                end
                else
                begin
                    data_ready_next = (int'(avail) > int'(rd_n));
                    if (rd_n == '0)
                    begin
                        push_cmd.status = ST_EMPTY;
                    end
                    else
                    begin
                        push_cmd.kind   = CMD_READ;
                        push_cmd.addr   = read_index_reg;
                        push_cmd.n      = rd_n;
                        read_index_next = RING_W'(rd_end);
                    end
                end
            end
            OP_FLUSH:
            begin
                data_ready_next  = 1'b0;
                read_index_next  = '0;
                write_index_next = '0;
            end
            default:
            begin
                push_cmd.kind = CMD_SINGLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_index_reg  <= '0;
            write_index_reg <= '0;
            data_ready_reg  <= 1'b0;
        end
        else if (push)
        begin
            read_index_reg  <= read_index_next;
            write_index_reg <= write_index_next;
            data_ready_reg  <= data_ready_next;
        end
    end

endmodule

### rtl/rdq_back.sv
// back end: executes queued commands on the ring and drives result words
module rdq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cq_valid,
    input  rdq_pkg::cmd_t      head,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rdq_pkg::out_word_t rsp_word
);
    import rdq_pkg::*;

    localparam logic [AW-1:0] RING_A = AW'(RING_SIZE);

    // byte offset within the current read
    logic [N_W-1:0]    idx_reg, idx_next;

    // issue stage, ring data arrives with it
    logic              a_valid_reg, a_valid_next;
    logic              a_byte_reg, a_byte_next;
    logic [1:0]        a_status_reg, a_status_next;
    logic [7:0]        a_count_reg, a_count_next;
    logic              a_last_reg, a_last_next;

    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;

    logic              b_free, a_adv, a_free, issue;
    logic              ram_we, ram_re;
    logic [RING_W-1:0] ram_raddr;
    logic [AW-1:0]     addr_sum;
    logic [7:0]        ram_rdata;
    logic              is_read, read_last;

    assign b_free  = !out_valid_reg || !rsp_stall;
    assign a_adv   = a_valid_reg && b_free;
    assign a_free  = !a_valid_reg || a_adv;
    assign issue   = cq_valid && a_free;
    assign is_read = (head.kind == CMD_READ);

    // ring address of the next byte, wrapping at the ring end
    always_comb
    begin
        addr_sum = AW'(head.addr) + AW'(idx_reg);
        if (addr_sum >= RING_A)
        begin
            addr_sum = addr_sum - RING_A;
        end
        ram_raddr = RING_W'(addr_sum);
        read_last = (idx_reg == head.n - 1'b1);
    end

    assign ram_re = issue && is_read;
    assign ram_we = issue && (head.kind == CMD_DEPOSIT);
    assign pop    = issue && (!is_read || read_last);

    rdq_ram #(
        .WIDTH(8),
        .DEPTH(RING_SIZE)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.addr),
        .wdata (head.wbyte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // issue stage and byte counter
    always_comb
    begin
        idx_next      = idx_reg;
        a_valid_next  = a_valid_reg;
        a_byte_next   = a_byte_reg;
        a_status_next = a_status_reg;
        a_count_next  = a_count_reg;
        a_last_next   = a_last_reg;
        if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
        if (issue)
        begin
            a_valid_next  = 1'b1;
            a_byte_next   = is_read;
            a_status_next = head.status;
            a_count_next  = head.count;
            a_last_next   = !is_read || read_last;
            if (is_read && !read_last)
            begin
                idx_next = idx_reg + 1'b1;
            end
            else
            begin
                idx_next = '0;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (a_adv)
        begin
            out_valid_next                = 1'b1;
            out_word_next.data_byte       = a_byte_reg ? ram_rdata : '0;
            out_word_next.status          = a_status_reg;
            out_word_next.published_count = a_count_reg;
            out_word_next.last            = a_last_reg;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_byte_reg   <= a_byte_next;
        a_status_reg <= a_status_next;
        a_count_reg  <= a_count_next;
        a_last_reg   <= a_last_next;
        out_word_reg <= out_word_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule
